// ===== design/jcs_pkg.sv =====
// Shared constants, types and byte classification for the JSON container splitter.
package jcs_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int DEPTH_BITS_DEF    = 8;
    localparam int OUT_BITS          = 16;
    localparam int ADDR_BITS         = 3;
    localparam int DATA_BITS         = 32;

    // Register indexes
    localparam logic [ADDR_BITS-3:0] REG_OBJECT_MODE = '0;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;

    typedef struct packed {
        logic opening;
        logic closing;
        logic blank;
        logic quote;
        logic bslash;
        logic arr_sep;
        logic obj_sep;
    } t_class;

    typedef struct packed {
        logic                hit;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        logic                nested;
        logic                key;
        logic                too_long;
    } t_result;

    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        c.opening = (b == CH_LBRACKET) || (b == CH_LBRACE);
        c.closing = (b == CH_RBRACKET) || (b == CH_RBRACE);
        c.blank   = (b == CH_SPACE) || (b == CH_NEWLINE) || (b == CH_TAB);
        c.quote   = (b == CH_QUOTE);
        c.bslash  = (b == CH_BSLASH);
        c.arr_sep = (b == CH_COMMA) || (b == CH_RBRACKET);
        c.obj_sep = (b == CH_COMMA) || (b == CH_COLON) || (b == CH_RBRACE);
        return c;
    endfunction

endpackage

// ===== design/jcs_apb_regs.sv =====
// APB register block holding the object mode bit.
module jcs_apb_regs
    import jcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output logic                 o_object_mode
);

    logic r_object_mode;
    logic n_object_mode;
    logic sel_mode;

    assign sel_mode = (paddr[ADDR_BITS-1:2] == REG_OBJECT_MODE);

    always_comb begin
        n_object_mode = r_object_mode;
        if (psel && penable && pwrite && sel_mode) begin
            n_object_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_object_mode <= 1'b0;
        end else begin
            r_object_mode <= n_object_mode;
        end
    end

    assign prdata        = sel_mode ? {{(DATA_BITS-1){1'b0}}, r_object_mode} : '0;
    assign pready        = 1'b1;
    assign o_object_mode = r_object_mode;

endmodule

// ===== design/jcs_tracker.sv =====
// Running text state and the one-byte step that finds slice boundaries.
module jcs_tracker
    import jcs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_text_byte,
    input  logic       i_first_byte,
    input  logic       i_object_mode,
    output t_result    o_result
);

    localparam int P  = POSITION_BITS;
    localparam int EW = (P + 1 > OUT_BITS) ? P + 1 : OUT_BITS;
    localparam logic [P-1:0]          POS_MAX   = '1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam logic [P:0]            SEG_INIT  = {{P{1'b0}}, 1'b1};

    logic [P-1:0]          r_pos, n_pos, c_pos;
    logic [P:0]            r_seg, n_seg, c_seg;
    logic [P-1:0]          r_first_nb, n_first_nb, c_first_nb;
    logic [P-1:0]          r_last_nb, n_last_nb, c_last_nb;
    logic                  r_seen, n_seen, c_seen;
    logic                  r_inq, n_inq, c_inq;
    logic                  r_bs, c_bs;
    logic                  r_expkey, n_expkey, c_expkey;
    logic [DEPTH_BITS-1:0] r_depth, n_depth, c_depth;

    t_class       cls;
    logic         sep;
    logic         blank;
    logic [P:0]   pos_p1;
    logic [EW-1:0] start_w;
    logic [EW-1:0] len_w;
    logic [DEPTH_BITS-1:0] depth_dec;

    assign cls    = classify(i_text_byte);
    assign sep    = i_object_mode ? cls.obj_sep : cls.arr_sep;
    assign pos_p1 = {1'b0, c_pos} + SEG_INIT;
    assign depth_dec = c_depth - {{(DEPTH_BITS-1){1'b0}}, 1'b1};

    // a marked first byte starts from the cleared state
    always_comb begin
        if (i_first_byte) begin
            c_pos      = '0;
            c_seg      = SEG_INIT;
            c_first_nb = '0;
            c_last_nb  = '0;
            c_seen     = 1'b0;
            c_inq      = 1'b0;
            c_bs       = 1'b0;
            c_expkey   = 1'b1;
            c_depth    = '0;
        end else begin
            c_pos      = r_pos;
            c_seg      = r_seg;
            c_first_nb = r_first_nb;
            c_last_nb  = r_last_nb;
            c_seen     = r_seen;
            c_inq      = r_inq;
            c_bs       = r_bs;
            c_expkey   = r_expkey;
            c_depth    = r_depth;
        end
    end

    always_comb begin
        n_seg      = c_seg;
        n_first_nb = c_first_nb;
        n_last_nb  = c_last_nb;
        n_seen     = c_seen;
        n_inq      = c_inq;
        n_expkey   = c_expkey;
        n_depth    = c_depth;
        blank      = cls.blank;
        start_w    = '0;
        len_w      = '0;
        o_result   = '0;

        priority if (c_pos == '0) begin
            // opener, skipped
        end else if (c_depth != '0) begin
            // nested run: quotes are not tracked here
            if (cls.opening) begin
                if (c_depth < DEPTH_MAX) begin
                    n_depth = c_depth + {{(DEPTH_BITS-1){1'b0}}, 1'b1};
                end
            end else if (cls.closing) begin
                n_depth = depth_dec;
                if (depth_dec == '0) begin
                    start_w         = EW'(c_seg);
                    len_w           = EW'(c_pos) - EW'(c_seg) + EW'(1);
                    o_result.hit    = 1'b1;
                    o_result.nested = 1'b1;
                    n_seg           = pos_p1;
                    n_seen          = 1'b0;
                end
            end
        end else if ((!i_object_mode || !c_expkey) && !c_inq && cls.opening) begin
            n_depth = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
            n_seg   = {1'b0, c_pos};
            n_seen  = 1'b0;
        end else begin
            if (cls.quote && !c_bs) begin
                n_inq = !c_inq;
            end else if (!c_inq && sep) begin
                if (c_seen) begin
                    start_w      = EW'(c_first_nb);
                    len_w        = EW'(c_last_nb) - EW'(c_first_nb) + EW'(1);
                    o_result.key = i_object_mode && c_expkey;
                    o_result.hit = 1'b1;
                end
                n_seen = 1'b0;
                n_seg  = pos_p1;
                if (i_object_mode) begin
                    n_expkey = !c_expkey;
                end
                blank = 1'b1;  // separator is not content
            end
            if (!blank) begin
                if (!c_seen) begin
                    n_first_nb = c_pos;
                    n_seen     = 1'b1;
                end
                n_last_nb = c_pos;
            end
        end

        o_result.start    = start_w[OUT_BITS-1:0];
        o_result.length   = len_w[OUT_BITS-1:0];
        o_result.too_long = (c_pos == POS_MAX);
    end

    assign n_pos = (c_pos < POS_MAX) ? c_pos + {{(P-1){1'b0}}, 1'b1} : c_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_seg      <= SEG_INIT;
            r_first_nb <= '0;
            r_last_nb  <= '0;
            r_seen     <= 1'b0;
            r_inq      <= 1'b0;
            r_bs       <= 1'b0;
            r_expkey   <= 1'b1;
            r_depth    <= '0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_seg      <= n_seg;
            r_first_nb <= n_first_nb;
            r_last_nb  <= n_last_nb;
            r_seen     <= n_seen;
            r_inq      <= n_inq;
            r_bs       <= cls.bslash;
            r_expkey   <= n_expkey;
            r_depth    <= n_depth;
        end
    end

endmodule

// ===== design/json_container_splitter.sv =====
// Top level of the JSON container splitter: word registers, handshake and register port.
//
// Takes one byte of a JSON array or object per cycle while the result side does not stall,
// and returns each top-level element as a start position and length. A byte enters the
// input register, is processed against the running text state once the pipe advances and,
// if it closes an element, leaves through the result register. A stalled result only holds
// the pipe back while it waits; no clearing pass is needed after reset. Set object_mode
// (address 0) only while the block is idle.
module json_container_splitter
    import jcs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_first_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_BITS-1:0]  o_slice_start,
    output logic [OUT_BITS-1:0]  o_slice_length,
    output logic                 o_nested_slice,
    output logic                 o_key_slice,
    output logic                 o_too_long,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       object_mode;
    logic       advance;
    logic       step;

    jcs_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_object_mode (object_mode)
    );

    jcs_tracker #(
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_text_byte   (r_in_byte),
        .i_first_byte  (r_in_first),
        .i_object_mode (object_mode),
        .o_result      (step_res)
    );

    // the pipe moves whenever the result register is free or being emptied
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= step && step_res.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_text_byte;
            r_in_first <= i_first_byte;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_slice_start  = r_out.start;
    assign o_slice_length = r_out.length;
    assign o_nested_slice = r_out.nested;
    assign o_key_slice    = r_out.key;
    assign o_too_long     = r_out.too_long;

endmodule

// ===== design/jcs_checker.sv =====
// Port-level checks for the JSON container splitter, bound to the top level.
module jcs_checker
    import jcs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [OUT_BITS-1:0] o_slice_start,
    input logic [OUT_BITS-1:0] o_slice_length,
    input logic                o_nested_slice,
    input logic                o_key_slice,
    input logic                o_too_long
);

    // a held result word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_slice_start)
            && $stable(o_slice_length) && $stable(o_nested_slice)
            && $stable(o_key_slice) && $stable(o_too_long))
        else $error("result word changed while stalled");

    // a bracketed slice is always a value
    a_nested_not_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_nested_slice && o_key_slice))
        else $error("nested slice flagged as key");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result pending straight after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> o_in_ready)
        else $error("input not ready straight after reset");

endmodule

bind json_container_splitter jcs_checker u_jcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_slice_start  (o_slice_start),
    .o_slice_length (o_slice_length),
    .o_nested_slice (o_nested_slice),
    .o_key_slice    (o_key_slice),
    .o_too_long     (o_too_long)
);

// ===== test/json_container_splitter_checker.sv =====
`timescale 1ns / 1ps
// Checker for the JSON container splitter: predicts each slice from the accepted bytes and compares.
module json_container_splitter_checker
    import jcs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_first_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [OUT_BITS-1:0]  i_slice_start,
    input  logic [OUT_BITS-1:0]  i_slice_length,
    input  logic                 i_nested_slice,
    input  logic                 i_key_slice,
    input  logic                 i_too_long,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [ADDR_BITS-1:0] i_paddr,
    input  logic [DATA_BITS-1:0] i_pwdata,
    input  logic [DATA_BITS-1:0] i_prdata,
    input  logic                 i_pready,
    output int                   o_errors,
    output int                   o_pending
);

    localparam logic [ADDR_BITS-1:0]     MODE_ADDR  = {REG_OBJECT_MODE, 2'b00};
    localparam logic [POSITION_BITS-1:0] POS_LAST   = '1;
    localparam logic [DEPTH_BITS-1:0]    DEPTH_LAST = '1;

    logic                     object_mode;
    logic [POSITION_BITS-1:0] txt_pos;
    logic [POSITION_BITS-1:0] run_begin;
    logic [POSITION_BITS-1:0] span_first;
    logic [POSITION_BITS-1:0] span_last;
    logic                     span_live;
    logic                     in_string;
    logic                     after_escape;
    logic                     want_key;
    logic [DEPTH_BITS-1:0]    run_depth;

    t_result slices_due[$];
    int      mismatch_count = 0;

    function automatic void clear_text();
        txt_pos      = '0;
        run_begin    = POSITION_BITS'(1);
        span_first   = '0;
        span_last    = '0;
        span_live    = 1'b0;
        in_string    = 1'b0;
        after_escape = 1'b0;
        want_key     = 1'b1;
        run_depth    = '0;
    endfunction

    // Advances the text state by one byte; hit marks a slice closed by it.
    function automatic t_result split_byte(input logic [7:0] ch, input logic fresh);
        t_result                  r;
        logic                     opening;
        logic                     closing;
        logic                     blank;
        logic                     sep;
        logic [POSITION_BITS-1:0] here;
        r       = '0;
        opening = (ch == CH_LBRACKET) || (ch == CH_LBRACE);
        closing = (ch == CH_RBRACKET) || (ch == CH_RBRACE);
        blank   = (ch == CH_SPACE) || (ch == CH_NEWLINE) || (ch == CH_TAB);
        if (fresh)
            clear_text();
        here = txt_pos;

        if (here == 0) begin
            // opener, skipped
        end else if (run_depth != 0) begin
            // nested run: brackets counted even inside quotes
            if (opening) begin
                if (run_depth != DEPTH_LAST)
                    run_depth++;
            end else if (closing) begin
                run_depth--;
                if (run_depth == 0) begin
                    r.hit     = 1'b1;
                    r.start   = OUT_BITS'(run_begin);
                    r.length  = OUT_BITS'(here - run_begin + 1'b1);
                    r.nested  = 1'b1;
                    run_begin = here + 1'b1;
                    span_live = 1'b0;
                end
            end
        end else if ((!object_mode || !want_key) && !in_string && opening) begin
            run_depth = DEPTH_BITS'(1);
            run_begin = here;
            span_live = 1'b0;
        end else begin
            if (object_mode)
                sep = (ch == CH_COMMA) || (ch == CH_COLON) || (ch == CH_RBRACE);
            else
                sep = (ch == CH_COMMA) || (ch == CH_RBRACKET);

            if (ch == CH_QUOTE && !after_escape) begin
                in_string = !in_string;
            end else if (!in_string && sep) begin
                if (span_live) begin
                    r.hit    = 1'b1;
                    r.start  = OUT_BITS'(span_first);
                    r.length = OUT_BITS'(span_last - span_first + 1'b1);
                    r.key    = object_mode && want_key;
                end
                span_live = 1'b0;
                run_begin = here + 1'b1;
                if (object_mode)
                    want_key = !want_key;
                blank = 1'b1;
            end
            if (!blank) begin
                if (!span_live) begin
                    span_first = here;
                    span_live  = 1'b1;
                end
                span_last = here;
            end
        end

        after_escape = (ch == CH_BSLASH);
        r.too_long   = (here == POS_LAST);
        if (txt_pos != POS_LAST)
            txt_pos++;
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            object_mode = 1'b0;
            clear_text();
            slices_due.delete();
        end else begin
            // the result leaving now cannot stem from the word accepted at this edge
            if (i_out_valid && i_out_ready) begin
                if (slices_due.size() == 0) begin
                    $display("%0t ns: slice mismatch, expected none, actual start %0h length %0h nested %0b key %0b too_long %0b",
                             $time, i_slice_start, i_slice_length, i_nested_slice, i_key_slice,
                             i_too_long);
                    mismatch_count++;
                end else begin
                    due = slices_due.pop_front();
                    check_field("slice_start", due.start, i_slice_start);
                    check_field("slice_length", due.length, i_slice_length);
                    check_field("nested_slice", due.nested, i_nested_slice);
                    check_field("key_slice", due.key, i_key_slice);
                    check_field("too_long", due.too_long, i_too_long);
                end
            end
            if (i_in_valid && i_in_ready) begin
                due = split_byte(i_text_byte, i_first_byte);
                if (due.hit)
                    slices_due.push_back(due);
            end
            if (i_psel && i_penable && i_pready && i_paddr == MODE_ADDR) begin
                if (i_pwrite)
                    object_mode = i_pwdata[0];
                else
                    check_field("object_mode readback", object_mode, i_prdata);
            end
        end
        o_pending = slices_due.size();
        o_errors  = mismatch_count;
    end

endmodule

// ===== test/json_container_splitter_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the JSON container splitter: clock, reset, stimulus and verdict.
module json_container_splitter_tb;
    import jcs_pkg::*;

    localparam logic [ADDR_BITS-1:0] MODE_ADDR   = {REG_OBJECT_MODE, 2'b00};
    localparam int                   LONG_HOLD   = 300;
    localparam int                   PHASE_BYTES = 20;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic [7:0]           i_text_byte    = '0;
    logic                 i_first_byte   = 1'b0;
    logic                 i_out_ready    = 1'b0;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [ADDR_BITS-1:0] paddr          = '0;
    logic [DATA_BITS-1:0] pwdata         = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [OUT_BITS-1:0]  o_slice_start;
    logic [OUT_BITS-1:0]  o_slice_length;
    logic                 o_nested_slice;
    logic                 o_key_slice;
    logic                 o_too_long;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    int mismatch_total;
    int expected_left;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int bytes_sent    = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    always #2 i_clk = ~i_clk;

    json_container_splitter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_first_byte  (i_first_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slice_start (o_slice_start),
        .o_slice_length(o_slice_length),
        .o_nested_slice(o_nested_slice),
        .o_key_slice   (o_key_slice),
        .o_too_long    (o_too_long),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    json_container_splitter_checker u_slice_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_first_byte  (i_first_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_slice_start (o_slice_start),
        .i_slice_length(o_slice_length),
        .i_nested_slice(o_nested_slice),
        .i_key_slice   (o_key_slice),
        .i_too_long    (o_too_long),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_errors      (mismatch_total),
        .o_pending     (expected_left)
    );

    // Result side: random stalls, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            i_out_ready  <= 1'b0;
            hold_left    <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_text(input logic [7:0] txt[$], input logic mark_first);
        for (int i = 0; i < txt.size(); i++) begin
            while ($urandom_range(0, 99) < idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid   <= 1'b1;
            i_text_byte  <= txt[i];
            i_first_byte <= mark_first && (i == 0);
            do @(posedge i_clk); while (!o_in_ready);
            bytes_sent++;
        end
    endtask

    // Drain everything; a byte that closes nothing may still be in flight, hence the tail
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_left != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= MODE_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mode(input logic obj);
        settle();
        apb_access(1'b1, DATA_BITS'(obj));
        @(posedge i_clk);
        apb_access(1'b0, '0);
    endtask

    function automatic void add_chars(ref logic [7:0] t[$], input string s);
        for (int k = 0; k < s.len(); k++)
            t.push_back(s[k]);
    endfunction

    function automatic void add_blanks(ref logic [7:0] t[$]);
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0:       t.push_back(CH_SPACE);
                1:       t.push_back(CH_NEWLINE);
                default: t.push_back(CH_TAB);
            endcase
        end
    endfunction

    // Quoted string, with separators, brackets and escapes inside
    function automatic void add_string(ref logic [7:0] t[$]);
        t.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 7))
                0: t.push_back(CH_COMMA);
                1: t.push_back(CH_COLON);
                2: t.push_back($urandom_range(0, 1) ? CH_LBRACKET : CH_RBRACE);
                3: t.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACKET);
                4: t.push_back(CH_SPACE);
                5: begin
                    t.push_back(CH_BSLASH);
                    t.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
                end
                default: t.push_back(8'(8'h61 + $urandom_range(0, 25)));
            endcase
        end
        t.push_back(CH_QUOTE);
    endfunction

    function automatic void add_value(ref logic [7:0] t[$], input int lvl);
        logic obj;
        int   n;
        add_blanks(t);
        case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 3)) t.push_back(8'(8'h30 + $urandom_range(0, 9)));
            3, 4:    add_string(t);
            5:       add_chars(t, $urandom_range(0, 1) ? "true" : "null");
            6, 7: begin
                if (lvl < 3) begin
                    obj = 1'($urandom_range(0, 1));
                    n   = $urandom_range(0, 3);
                    t.push_back(obj ? CH_LBRACE : CH_LBRACKET);
                    for (int i = 0; i < n; i++) begin
                        if (i != 0)
                            t.push_back(CH_COMMA);
                        if (obj) begin
                            add_string(t);
                            t.push_back(CH_COLON);
                        end
                        add_value(t, lvl + 1);
                    end
                    t.push_back(obj ? CH_RBRACE : CH_RBRACKET);
                end else begin
                    add_string(t);
                end
            end
            8:       ; // empty element
            default: t.push_back(8'($urandom_range(0, 255)));
        endcase
        add_blanks(t);
    endfunction

    // Mostly well-formed container text, with the odd corrupted word or trailing junk
    function automatic void make_text(ref logic [7:0] t[$], input logic obj);
        int n;
        n = $urandom_range(0, 5);
        t.delete();
        t.push_back(obj ? CH_LBRACE : CH_LBRACKET);
        for (int i = 0; i < n; i++) begin
            if (i != 0)
                t.push_back(CH_COMMA);
            if (obj) begin
                add_blanks(t);
                if ($urandom_range(0, 7) == 0)
                    add_value(t, 0);
                else
                    add_string(t);
                add_blanks(t);
                t.push_back(CH_COLON);
            end
            add_value(t, 0);
        end
        t.push_back(obj ? CH_RBRACE : CH_RBRACKET);
        if ($urandom_range(0, 9) == 0)
            t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            add_value(t, 0);
    endfunction

    initial begin
        logic [7:0] txt[$];
        int         goal;
        int         idle_tab[4]  = '{0, 63, 0, 28};
        int         stall_tab[4] = '{0, 0, 63, 28};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(1'b0);

        // unmarked opener straight after reset; trimming, escaped quote, empty element
        txt.delete();
        add_chars(txt, "[ 1 ,\t\"a,\\\"]\" ,, x\n]");
        send_text(txt, 1'b0);
        // junk before a bracket, nested run, zero and all-ones words, bytes after the closer
        txt.delete();
        add_chars(txt, "[ab[1,[2]] ,");
        txt.push_back(8'h00);
        txt.push_back(CH_COMMA);
        txt.push_back(8'hFF);
        add_chars(txt, "]7,");
        send_text(txt, 1'b1);

        set_mode(1'b1);
        // keys, nested value, bracket in key position, empty span after a nested value
        txt.delete();
        add_chars(txt, "{\"k\" : \"v\", \"a\":[1,{2}] , [q]:{\"x\":1},\"n\":}");
        send_text(txt, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            for (int m = 0; m < 2; m++) begin
                set_mode(m[0]);
                idle_pct  = idle_tab[ph];
                stall_pct <= stall_tab[ph];
                goal = bytes_sent + PHASE_BYTES;
                while (bytes_sent < goal) begin
                    make_text(txt, m[0] ^ ($urandom_range(0, 9) == 0));
                    send_text(txt, $urandom_range(0, 9) != 0);
                end
            end
        end

        // long hold-off on the result side while words keep coming
        set_mode(1'b0);
        idle_pct      = 0;
        stall_pct     <= 0;
        hold_requests <= hold_requests + 1;
        txt.delete();
        txt.push_back(CH_LBRACKET);
        repeat (60) begin
            txt.push_back(8'(8'h30 + $urandom_range(0, 9)));
            txt.push_back(CH_COMMA);
        end
        txt.push_back(CH_RBRACKET);
        send_text(txt, 1'b1);

        settle();
        if (mismatch_total == 0 && expected_left == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/jcs_pkg.sv
design/jcs_apb_regs.sv
design/jcs_tracker.sv
design/json_container_splitter.sv
design/jcs_checker.sv
test/json_container_splitter_checker.sv
test/json_container_splitter_tb.sv
